>>> hw/rtl/tkpr_pkg.sv
`default_nettype none
package tkpr_pkg;
	localparam int MaxDims = 4;
	localparam int MaxEdge = 256;
	localparam int DimW = $clog2(MaxDims);
	localparam int EdgeW = $clog2(MaxEdge);
	localparam int TblW = DimW + EdgeW;
	localparam int LenW = 9;
	localparam int KeyW = 63;

	typedef enum logic [1:0] {
		KIND_LEN = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_FWD = 2'd2,
		KIND_INV = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] dimension;
		logic [7:0] entry_index;
		logic [7:0] mapped_coordinate;
		logic excluded;
		logic [8:0] old_length;
		logic [8:0] new_length;
		logic has_permutation;
		logic [62:0] key;
		logic [63:0] value;
		logic last_of_batch;
	} in_beat_t;

	typedef struct packed {
		logic [62:0] new_key;
		logic [63:0] data_word;
		logic [62:0] slot;
		logic fault;
		logic batch_end;
	} out_beat_t;

	function automatic logic [LenW-1:0] clamp_len(input logic [8:0] v);
		logic [LenW-1:0] r;
		r = v;
		if (v == 9'd0) r = LenW'(1);
		else if (32'(v) > MaxEdge) r = LenW'(MaxEdge);
		return r;
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/tkpr_fifo.sv
`default_nettype none
module tkpr_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire tkpr_pkg::in_beat_t wr_data,
	input wire logic wr_valid,
	output logic wr_ready,
	output tkpr_pkg::in_beat_t rd_data,
	output logic rd_valid,
	input wire logic rd_ready
);
	import tkpr_pkg::*;
	in_beat_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/tkpr_divider.sv
`default_nettype none
module tkpr_divider (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [62:0] dividend,
	input wire logic [8:0] divisor,
	output logic done,
	output logic [62:0] quotient,
	output logic [8:0] remainder
);
	import tkpr_pkg::*;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [62:0] quo_q;
	logic [9:0] rem_q;
	logic [8:0] div_q;
	logic [9:0] trial;
	logic [9:0] sh;

	assign sh = {rem_q[8:0], quo_q[62]};
	assign trial = sh - {1'b0, div_q};
	assign quotient = quo_q;
	assign remainder = rem_q[8:0];

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[9]) begin
				rem_q <= trial;
				quo_q <= {quo_q[61:0], 1'b1};
			end else begin
				rem_q <= sh;
				quo_q <= {quo_q[61:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd62) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/tkpr_engine.sv
`default_nettype none
module tkpr_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [3:0] dimension_count,
	input wire tkpr_pkg::in_beat_t cmd,
	input wire logic cmd_valid,
	output logic cmd_ready,
	output tkpr_pkg::out_beat_t out_beat,
	output logic out_valid,
	input wire logic out_ready
);
	import tkpr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_DIV, ST_WAIT, ST_LOOK, ST_RDWAIT, ST_ACC, ST_MUL, ST_FINISH
	} state_t;

	state_t state_q;
	logic [LenW-1:0] old_len_q [MaxDims];
	logic [LenW-1:0] new_len_q [MaxDims];
	logic [MaxDims-1:0] perm_q;
	logic [EdgeW:0] fwd_mem [MaxEdge*MaxDims];
	logic [EdgeW-1:0] inv_mem [MaxEdge*MaxDims];
	logic inv_set_mem [MaxEdge*MaxDims];
	logic [EdgeW:0] fwd_rd_q;
	logic [EdgeW-1:0] inv_rd_q;
	logic inv_set_rd_q;
	logic [EdgeW:0] clr_q;
	logic [DimW-1:0] clr_dim_q;
	logic [3:0] j_q;
	logic [3:0] n_dims;
	logic [62:0] wkey_q, knew_q, lda_q, slot_q;
	logic [8:0] digit_q;
	logic [8:0] mapped_q;
	logic outside_q, fault_q;
	logic div_start, div_done;
	logic [62:0] div_quo;
	logic [8:0] div_rem;
	logic fwd_mode;
	logic [DimW-1:0] jd;
	logic [TblW-1:0] rd_addr;
	logic [TblW-1:0] wr_addr_f, wr_addr_i;
	logic do_entry;
	logic [62:0] prod_q;

	assign fwd_mode = cmd.kind == KIND_FWD;
	assign n_dims = (32'(dimension_count) > MaxDims) ? 4'(MaxDims) : dimension_count;
	assign jd = j_q[DimW-1:0];
	assign rd_addr = {jd, digit_q[EdgeW-1:0]};
	assign wr_addr_f = {cmd.dimension[DimW-1:0], cmd.entry_index[EdgeW-1:0]};
	assign wr_addr_i = {cmd.dimension[DimW-1:0], cmd.mapped_coordinate[EdgeW-1:0]};
	assign do_entry = state_q == ST_IDLE && cmd_valid && cmd.kind == KIND_ENTRY
		&& 32'(cmd.dimension) < MaxDims && 32'(cmd.entry_index) < MaxEdge;
	assign div_start = state_q == ST_DIV;

	tkpr_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(wkey_q),
		.divisor(fwd_mode ? old_len_q[jd] : new_len_q[jd]),
		.done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	always_ff @(posedge clk) begin
		if (do_entry) begin
			fwd_mem[wr_addr_f] <= {cmd.excluded, cmd.mapped_coordinate[EdgeW-1:0]};
			if (!cmd.excluded && 32'(cmd.mapped_coordinate) < MaxEdge) begin
				inv_mem[wr_addr_i] <= cmd.entry_index[EdgeW-1:0];
			end
		end
		fwd_rd_q <= fwd_mem[rd_addr];
		inv_rd_q <= inv_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) inv_set_mem[{clr_dim_q, clr_q[EdgeW-1:0]}] <= 1'b0;
		else if (do_entry && !cmd.excluded && 32'(cmd.mapped_coordinate) < MaxEdge)
			inv_set_mem[wr_addr_i] <= 1'b1;
		inv_set_rd_q <= inv_set_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			clr_dim_q <= '0;
			for (int d = 0; d < MaxDims; d++) begin
				old_len_q[d] <= LenW'(1);
				new_len_q[d] <= LenW'(1);
			end
			perm_q <= '0;
			slot_q <= '0;
			out_valid <= 1'b0;
			cmd_ready <= 1'b0;
			j_q <= '0;
		end else begin
			cmd_ready <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q[EdgeW-1:0] == '1) begin
						clr_q <= '0;
						if (clr_q[EdgeW] || clr_dim_q == DimW'(MaxDims - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							clr_dim_q <= clr_dim_q + 1'b1;
						end
					end
				end
				ST_IDLE: begin
					if (cmd_valid && !cmd_ready) begin
						case (cmd.kind)
							KIND_LEN: begin
								cmd_ready <= 1'b1;
								if (32'(cmd.dimension) < MaxDims) begin
									old_len_q[cmd.dimension[DimW-1:0]] <= clamp_len(cmd.old_length);
									new_len_q[cmd.dimension[DimW-1:0]] <= clamp_len(cmd.new_length);
									perm_q[cmd.dimension[DimW-1:0]] <= cmd.has_permutation;
									clr_dim_q <= cmd.dimension[DimW-1:0];
									clr_q <= {1'b1, {EdgeW{1'b0}}};
									state_q <= ST_CLEAR;
								end
							end
							KIND_ENTRY: cmd_ready <= 1'b1;
							default: begin
								if (!out_valid) begin
									wkey_q <= cmd.key;
									knew_q <= '0;
									lda_q <= 63'd1;
									j_q <= '0;
									outside_q <= 1'b0;
									fault_q <= 1'b0;
									state_q <= (n_dims == 4'd0) ? ST_FINISH : ST_DIV;
								end
							end
						endcase
					end
				end
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						digit_q <= div_rem;
						wkey_q <= div_quo;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: state_q <= ST_RDWAIT;
				ST_RDWAIT: begin
					mapped_q <= digit_q;
					if (perm_q[jd]) begin
						if (fwd_mode) begin
							if (fwd_rd_q[EdgeW]) begin
								outside_q <= 1'b1;
								mapped_q <= '0;
							end else mapped_q <= 9'(fwd_rd_q[EdgeW-1:0]);
						end else begin
							if (inv_set_rd_q) mapped_q <= 9'(inv_rd_q);
							else begin
								fault_q <= 1'b1;
								mapped_q <= '0;
							end
						end
					end
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					prod_q <= 63'(lda_q * 63'(mapped_q));
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					knew_q <= knew_q + prod_q;
					lda_q <= 63'(lda_q * 63'(fwd_mode ? new_len_q[jd] : old_len_q[jd]));
					j_q <= j_q + 4'd1;
					state_q <= (j_q + 4'd1 == n_dims) ? ST_FINISH : ST_DIV;
				end
				ST_FINISH: begin
					cmd_ready <= 1'b1;
					state_q <= ST_IDLE;
					if (!outside_q) begin
						out_valid <= 1'b1;
						out_beat.new_key <= knew_q;
						out_beat.data_word <= cmd.value;
						out_beat.slot <= slot_q;
						out_beat.fault <= fault_q;
						out_beat.batch_end <= cmd.last_of_batch;
						slot_q <= cmd.last_of_batch ? '0 : slot_q + 63'd1;
					end else if (cmd.last_of_batch) slot_q <= '0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/tensor_key_permute_remap.sv
// Remap of one pair: per active dimension, the 63-step shared divider, a table
// read and a multiply-accumulate, plus decode, finish and pop; a length write
// adds a clear of that dimension's inverse store. A waiting result holds off
// the next remap. One item at a time in the back end; a 2-deep queue decouples
// the input. After reset the inverse store is cleared before the first item is
// taken; lengths reset to 1, no permutation, slot 0.
`default_nettype none
module tensor_key_permute_remap (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [3:0] cfg_wdata,
	input wire tkpr_pkg::in_beat_t in_data,
	input wire logic in_valid,
	output logic in_ready,
	output tkpr_pkg::out_beat_t out_data,
	output logic out_valid,
	input wire logic out_ready
);
	import tkpr_pkg::*;
	logic [3:0] dim_cnt_q;
	in_beat_t q_data;
	logic q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dim_cnt_q <= 4'd1;
		else if (cfg_we) dim_cnt_q <= cfg_wdata;
	end

	tkpr_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_data(in_data), .wr_valid(in_valid),
		.wr_ready(in_ready), .rd_data(q_data), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	tkpr_engine u_engine (
		.clk(clk), .arst_n(arst_n), .dimension_count(dim_cnt_q), .cmd(q_data),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .out_beat(out_data),
		.out_valid(out_valid), .out_ready(out_ready)
	);
endmodule
`default_nettype wire
